// ===== hdl/hid_keypad_number_entry_unit_macros.svh =====
// Assertion macros used by the port-level checker of the keypad number entry block
`ifndef HID_KEYPAD_NUMBER_ENTRY_UNIT_MACROS_SVH
`define HID_KEYPAD_NUMBER_ENTRY_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset
`define HKNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define HKNE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hkne_pkg.sv =====
// Shared types, keycodes and key decoding for the keypad number entry block
package hkne_pkg;

  localparam int KEY_W   = 8;
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 3;

  // HID usage codes of interest
  localparam logic [KEY_W-1:0] KEY_NONE      = 8'h00;
  localparam logic [KEY_W-1:0] KEY_ROLLOVER  = 8'h01;
  localparam logic [KEY_W-1:0] KEY_DIGIT_1   = 8'h1E;
  localparam logic [KEY_W-1:0] KEY_DIGIT_9   = 8'h26;
  localparam logic [KEY_W-1:0] KEY_DIGIT_0   = 8'h27;
  localparam logic [KEY_W-1:0] KEY_ENTER     = 8'h28;
  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'h2A;
  localparam logic [KEY_W-1:0] KEY_KP_ENTER  = 8'h58;
  localparam logic [KEY_W-1:0] KEY_KP_1      = 8'h59;
  localparam logic [KEY_W-1:0] KEY_KP_9      = 8'h61;
  localparam logic [KEY_W-1:0] KEY_KP_0      = 8'h62;

  typedef enum logic [1:0] {
    KC_NONE,
    KC_DIGIT,
    KC_ENTER,
    KC_BACK
  } key_class_t;

  // What one lane found in its key slot
  typedef struct packed {
    logic                 active;
    key_class_t           cls;
    logic [DIGIT_W-1:0]   value;
  } lane_res_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SLOT,
    SQ_FETCH,
    SQ_EMIT
  } seq_state_t;

  function automatic key_class_t key_class(input logic [KEY_W-1:0] code);
    key_class_t cls;
    cls = KC_NONE;
    if ((code >= KEY_DIGIT_1 && code <= KEY_DIGIT_0) ||
        (code >= KEY_KP_1 && code <= KEY_KP_0)) begin
      cls = KC_DIGIT;
    end else if (code == KEY_ENTER || code == KEY_KP_ENTER) begin
      cls = KC_ENTER;
    end else if (code == KEY_BACKSPACE) begin
      cls = KC_BACK;
    end
    return cls;
  endfunction

  // Digit value; zero keys and non-digits give 0
  function automatic logic [DIGIT_W-1:0] key_value(input logic [KEY_W-1:0] code);
    logic [KEY_W-1:0] diff;
    logic [DIGIT_W-1:0] val;
    diff = '0;
    val  = '0;
    if (code >= KEY_DIGIT_1 && code <= KEY_DIGIT_9) begin
      diff = code - (KEY_DIGIT_1 - 8'd1);
      val  = diff[DIGIT_W-1:0];
    end else if (code >= KEY_KP_1 && code <= KEY_KP_9) begin
      diff = code - (KEY_KP_1 - 8'd1);
      val  = diff[DIGIT_W-1:0];
    end
    return val;
  endfunction

endpackage

// ===== hdl/hkne_lane.sv =====
// One key slot lane: newness check against the previous report and key decode
module hkne_lane
  import hkne_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  logic             slot_on,
  input  logic [KEY_W-1:0] code,
  input  logic [KEY_W-1:0] prev [KEY_SLOTS],
  output lane_res_t        res
);

  logic seen;

  // Look for the code in every slot of the previous report
  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (prev[j] == code) seen = 1'b1;
    end
  end

  // Flag a fresh key and decode it
  always_comb begin
    res.active = slot_on && (code != KEY_NONE) && (code != KEY_ROLLOVER) && !seen;
    res.cls    = key_class(code);
    res.value  = key_value(code);
  end

endmodule

// ===== hdl/hkne_seq.sv =====
// Merging sequencer: applies lane results in slot order, holds the digit store
module hkne_seq
  import hkne_pkg::*;
#(
  parameter int KEY_SLOTS  = 6,
  parameter int MAX_DIGITS = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lane_res_t          lanes [KEY_SLOTS],
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DIGIT_W-1:0] out_digit,
  output logic               out_last
);

  localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LEN_W  = $clog2(MAX_DIGITS + 1);
  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_DIGITS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(KEY_SLOTS - 1);

  seq_state_t          state, state_next;
  lane_res_t           slots [KEY_SLOTS];
  logic [SLOT_W-1:0]   idx, idx_next;
  logic [LEN_W-1:0]    len, len_next;
  logic [ADDR_W-1:0]   k, k_next;
  logic [ADDR_W-1:0]   rd_addr;
  logic [DIGIT_W-1:0]  rd_data;
  logic [DIGIT_W-1:0]  mem [MAX_DIGITS];
  logic                wr_en;
  logic                load;
  logic                k_last;
  lane_res_t           cur;

  assign cur    = slots[idx];
  assign load   = (state == SQ_EMIT) && (!out_valid || out_ready);
  assign k_last = ((LEN_W'(k) + LEN_W'(1)) == len);
  assign busy   = (state != SQ_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      SQ_IDLE: begin
        if (start) state_next = SQ_SLOT;
      end
      SQ_SLOT: begin
        if (cur.active && cur.cls == KC_ENTER && len != '0) begin
          state_next = SQ_FETCH;
        end else if (idx == SLOT_LAST) begin
          state_next = SQ_IDLE;
        end
      end
      SQ_FETCH: state_next = SQ_EMIT;
      SQ_EMIT: begin
        if (load && k_last) begin
          state_next = (idx == SLOT_LAST) ? SQ_IDLE : SQ_SLOT;
        end
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    idx_next = idx;
    len_next = len;
    k_next   = k;
    wr_en    = 1'b0;
    rd_addr  = k;
    case (state)
      SQ_IDLE: begin
        idx_next = '0;
      end
      SQ_SLOT: begin
        if (cur.active && cur.cls == KC_DIGIT && len < LEN_MAX) begin
          wr_en    = 1'b1;
          len_next = len + LEN_W'(1);
        end else if (cur.active && cur.cls == KC_BACK && len != '0) begin
          len_next = len - LEN_W'(1);
        end
        if (!(cur.active && cur.cls == KC_ENTER && len != '0) && idx != SLOT_LAST) begin
          idx_next = idx + SLOT_W'(1);
        end
      end
      SQ_FETCH: begin
        k_next  = '0;
        rd_addr = '0;
      end
      SQ_EMIT: begin
        if (load) begin
          k_next  = k + ADDR_W'(1);
          rd_addr = k + ADDR_W'(1);
          if (k_last) begin
            len_next = '0;
            if (idx != SLOT_LAST) idx_next = idx + SLOT_W'(1);
          end
        end
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SQ_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Slot results, counters and output payload
  always_ff @(posedge clk) begin
    idx <= idx_next;
    k   <= k_next;
    if (start && state == SQ_IDLE) slots <= lanes;
    if (load) begin
      out_digit <= rd_data;
      out_last  <= k_last;
    end
  end

  // Digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[len[ADDR_W-1:0]] <= cur.value;
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/hid_keypad_number_entry_unit.sv =====
// Top level of the keypad number entry block: input channel, lanes and sequencer
//
// Takes one boot-protocol keyboard report or a disconnect per item and returns
// the digits of each number closed by Enter, one item per digit, last marking
// the final one. A disconnect, or a report with a zero key count, does not
// start the slot walk. For any other report the lanes judge all slots at once
// and the sequencer applies them one a cycle, but each Enter that flushes
// digits holds the walk while they are read out of the digit store one by
// one, since it has one read port, and while the output stalls. The worst case
// report with the default sizes flushes 35 digits over two Enters. The output
// register lets the next report be taken while the last digit still waits.
module hid_keypad_number_entry_unit
  import hkne_pkg::*;
#(
  parameter int MAX_DIGITS = 31,
  parameter int KEY_SLOTS  = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [COUNT_W-1:0] slots_used,
  input  logic [KEY_W-1:0]   key_0,
  input  logic [KEY_W-1:0]   key_1,
  input  logic [KEY_W-1:0]   key_2,
  input  logic [KEY_W-1:0]   key_3,
  input  logic [KEY_W-1:0]   key_4,
  input  logic [KEY_W-1:0]   key_5,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DIGIT_W-1:0] digit,
  output logic               last
);

  localparam logic [COUNT_W-1:0] SLOTS_C = COUNT_W'(KEY_SLOTS);

  logic [KEY_W-1:0]   keys [6];
  logic [KEY_W-1:0]   prev [KEY_SLOTS];
  logic [COUNT_W-1:0] count;
  logic               accept;
  logic               start;
  logic               busy;
  lane_res_t          lanes [KEY_SLOTS];

  assign keys[0] = key_0;
  assign keys[1] = key_1;
  assign keys[2] = key_2;
  assign keys[3] = key_3;
  assign keys[4] = key_4;
  assign keys[5] = key_5;

  // Saturate the slot count and qualify the item
  assign count    = (slots_used > SLOTS_C) ? SLOTS_C : slots_used;
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign start    = accept && !opcode && (slots_used != '0);

  // One lane per key slot
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
    hkne_lane #(
      .KEY_SLOTS (KEY_SLOTS)
    ) u_lane (
      .slot_on (COUNT_W'(i) < count),
      .code    (keys[i]),
      .prev    (prev),
      .res     (lanes[i])
    );
  end

  // Replace the previous-key set on a report with a nonzero key count, clear it on disconnect
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < KEY_SLOTS; j++) prev[j] <= '0;
    end else if (accept && opcode) begin
      for (int j = 0; j < KEY_SLOTS; j++) prev[j] <= '0;
    end else if (start) begin
      for (int j = 0; j < KEY_SLOTS; j++) begin
        prev[j] <= (COUNT_W'(j) < count) ? keys[j] : '0;
      end
    end
  end

  hkne_seq #(
    .KEY_SLOTS  (KEY_SLOTS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .lanes     (lanes),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_digit (digit),
    .out_last  (last)
  );

endmodule

// ===== hdl/hkne_checker.sv =====
// Port-level checks of the keypad number entry block and their binding
`include "hid_keypad_number_entry_unit_macros.svh"

module hkne_checker
  import hkne_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DIGIT_W-1:0] digit,
  input logic               last
);

  // Hold a stalled result item
  `HKNE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(digit) && $stable(last), "stalled result item changed")

  // Emit decimal digits only
  `HKNE_ASSERT(a_digit_range, out_valid |-> digit <= 4'd9, "digit above nine")

  // Refuse new items while a number is still being flushed
  `HKNE_ASSERT(a_busy_flush, out_valid && !last |-> !in_ready, "item taken during a flush")

  // Drop any pending result on reset
  `HKNE_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid after reset")

endmodule

bind hid_keypad_number_entry_unit hkne_checker u_hkne_checker (.*);

// ===== tb/sv/tb_hid_keypad_number_entry_unit.sv =====
// Self-checking testbench for the keypad number entry block
module tb_hid_keypad_number_entry_unit
  import hkne_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH   = 31;
  localparam int SLOT_COUNT   = 6;
  localparam int RANDOM_ITEMS = 310;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic OP_REPORT     = 1'b0;
  localparam logic OP_DISCONNECT = 1'b1;

  typedef struct packed {
    logic                                opcode;
    logic [COUNT_W-1:0]                  slots_used;
    logic [SLOT_COUNT-1:0][KEY_W-1:0]    keys;
  } report_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } digit_item_t;

  // Track the line buffer and held keys, and hold the digits still owed
  class entry_scoreboard;
    logic [KEY_W-1:0]   held_keys [SLOT_COUNT];
    logic [DIGIT_W-1:0] line_digits [LINE_DEPTH];
    int unsigned        line_len;
    digit_item_t        pending_digits [$];
    int unsigned        errors;

    function new();
      foreach (held_keys[i]) held_keys[i] = KEY_NONE;
      line_len = 0;
      errors   = 0;
    endfunction

    // Decode a keycode into its class and digit value
    function key_class_t decode_key(input logic [KEY_W-1:0] code,
                                    output logic [DIGIT_W-1:0] val);
      logic [KEY_W-1:0] offset;
      key_class_t       cls;
      cls    = KC_NONE;
      val    = '0;
      offset = '0;
      if (code >= KEY_DIGIT_1 && code <= KEY_DIGIT_9) begin
        cls    = KC_DIGIT;
        offset = code - KEY_DIGIT_1 + 8'd1;
      end else if (code >= KEY_KP_1 && code <= KEY_KP_9) begin
        cls    = KC_DIGIT;
        offset = code - KEY_KP_1 + 8'd1;
      end else if (code == KEY_DIGIT_0 || code == KEY_KP_0) begin
        cls = KC_DIGIT;
      end else if (code == KEY_ENTER || code == KEY_KP_ENTER) begin
        cls = KC_ENTER;
      end else if (code == KEY_BACKSPACE) begin
        cls = KC_BACK;
      end
      val = offset[DIGIT_W-1:0];
      return cls;
    endfunction

    // Apply one accepted item and queue the digits it releases
    function void note_report(input report_t rep);
      int unsigned        used;
      logic [KEY_W-1:0]   code;
      logic [DIGIT_W-1:0] val;
      key_class_t         cls;
      bit                 held;
      digit_item_t        item;
      if (rep.opcode == OP_DISCONNECT) begin
        foreach (held_keys[i]) held_keys[i] = KEY_NONE;
        return;
      end
      used = rep.slots_used;
      if (used == 0) return;
      if (used > SLOT_COUNT) used = SLOT_COUNT;
      for (int i = 0; i < used; i++) begin
        code = rep.keys[i];
        if (code == KEY_NONE || code == KEY_ROLLOVER) continue;
        held = 1'b0;
        foreach (held_keys[j]) if (held_keys[j] == code) held = 1'b1;
        if (held) continue;
        cls = decode_key(code, val);
        case (cls)
          KC_DIGIT: begin
            if (line_len < LINE_DEPTH) begin
              line_digits[line_len] = val;
              line_len++;
            end
          end
          KC_BACK: begin
            if (line_len > 0) line_len--;
          end
          KC_ENTER: begin
            for (int k = 0; k < line_len; k++) begin
              item.digit = line_digits[k];
              item.last  = (k == line_len - 1);
              pending_digits.push_back(item);
            end
            line_len = 0;
          end
          default: ;
        endcase
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        held_keys[i] = (i < used) ? rep.keys[i] : KEY_NONE;
      end
    endfunction

    // Compare one accepted digit with the oldest one owed
    function void check_digit(input logic [DIGIT_W-1:0] got_digit, input logic got_last);
      digit_item_t want;
      if (pending_digits.size() == 0) begin
        $error("digit %0d last %0b arrived with nothing owed", got_digit, got_last);
        errors++;
        return;
      end
      want = pending_digits.pop_front();
      if (got_digit !== want.digit) begin
        $error("digit: expected %0d, got %0d", want.digit, got_digit);
        errors++;
      end
      if (got_last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got_last);
        errors++;
      end
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               opcode     = OP_REPORT;
  logic [COUNT_W-1:0] slots_used = '0;
  logic [KEY_W-1:0]   key_0      = KEY_NONE;
  logic [KEY_W-1:0]   key_1      = KEY_NONE;
  logic [KEY_W-1:0]   key_2      = KEY_NONE;
  logic [KEY_W-1:0]   key_3      = KEY_NONE;
  logic [KEY_W-1:0]   key_4      = KEY_NONE;
  logic [KEY_W-1:0]   key_5      = KEY_NONE;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [DIGIT_W-1:0] digit;
  logic               last;

  entry_scoreboard sb = new();
  report_t         last_sent;
  bit              send_burst = 1'b0;
  bit              take_burst = 1'b0;
  int unsigned     quiet_cycles = 0;

  hid_keypad_number_entry_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .slots_used (slots_used),
    .key_0      (key_0),
    .key_1      (key_1),
    .key_2      (key_2),
    .key_3      (key_3),
    .key_4      (key_4),
    .key_5      (key_5),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit      (digit),
    .last       (last)
  );

  always #5 clk = ~clk;

  // Build a report item; unused slots default to no key
  function automatic report_t key_report(input int cnt,
                                         input logic [KEY_W-1:0] k0 = KEY_NONE,
                                         input logic [KEY_W-1:0] k1 = KEY_NONE,
                                         input logic [KEY_W-1:0] k2 = KEY_NONE,
                                         input logic [KEY_W-1:0] k3 = KEY_NONE,
                                         input logic [KEY_W-1:0] k4 = KEY_NONE,
                                         input logic [KEY_W-1:0] k5 = KEY_NONE);
    report_t rep;
    rep.opcode     = OP_REPORT;
    rep.slots_used = COUNT_W'(cnt);
    rep.keys       = {k5, k4, k3, k2, k1, k0};
    return rep;
  endfunction

  // Disconnect item with random leftover fields
  function automatic report_t unplug_report();
    report_t rep;
    rep.opcode     = OP_DISCONNECT;
    rep.slots_used = COUNT_W'($urandom_range(0, 7));
    foreach (rep.keys[i]) rep.keys[i] = KEY_W'($urandom_range(0, 255));
    return rep;
  endfunction

  // Pick one keycode, leaning towards digits so that numbers build up
  function automatic logic [KEY_W-1:0] random_key(input report_t prev);
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 19);
    if (roll < 45) begin
      return (pick < 10) ? KEY_W'(KEY_DIGIT_1 + pick) : KEY_W'(KEY_KP_1 + (pick - 10));
    end else if (roll < 55) begin
      return pick[0] ? KEY_ENTER : KEY_KP_ENTER;
    end else if (roll < 63) begin
      return KEY_BACKSPACE;
    end else if (roll < 70) begin
      return prev.keys[$urandom_range(0, SLOT_COUNT - 1)];
    end else if (roll < 78) begin
      return pick[0] ? KEY_ROLLOVER : KEY_NONE;
    end
    return KEY_W'($urandom_range(0, 255));
  endfunction

  // Drive one item after a random gap and wait for it to be taken
  task automatic send_report(input report_t rep);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= rep.opcode;
    slots_used <= rep.slots_used;
    key_0      <= rep.keys[0];
    key_1      <= rep.keys[1];
    key_2      <= rep.keys[2];
    key_3      <= rep.keys[3];
    key_4      <= rep.keys[4];
    key_5      <= rep.keys[5];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_report(rep);
    last_sent = rep;
  endtask

  // Take digits with random stalls and check each one
  initial begin
    int unsigned stall;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_digit(digit, last);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    report_t          rep;
    logic [KEY_W-1:0] fill_code;
    int unsigned      counted;
    int unsigned      cnt;
    last_sent = key_report(0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: both digit rows, Enter, held keys, empty buffer
    send_report(key_report(1, KEY_DIGIT_1));
    send_report(key_report(4, KEY_DIGIT_0, KEY_KP_0, KEY_KP_1, KEY_KP_9));
    send_report(key_report(1, KEY_ENTER));
    send_report(key_report(1, KEY_ENTER));
    send_report(key_report(2, KEY_BACKSPACE, KEY_KP_ENTER));
    send_report(key_report(4, KEY_DIGIT_9, 8'h1F, KEY_BACKSPACE, KEY_KP_ENTER));
    // Zero count leaves everything alone
    send_report(key_report(0, KEY_DIGIT_1, KEY_ENTER, KEY_DIGIT_1, KEY_DIGIT_1,
                           KEY_ENTER, KEY_BACKSPACE));
    send_report(key_report(1, KEY_DIGIT_9));
    // Oversized count, reserved codes and a repeated key in one report
    send_report(key_report(7, KEY_NONE, KEY_ROLLOVER, 8'h21, 8'h21, 8'h5A, KEY_ENTER));
    // Disconnect forgets held keys but keeps the buffer
    send_report(unplug_report());
    send_report(key_report(2, 8'h21, KEY_ENTER));
    // Slots past the count are remembered as no key
    send_report(key_report(1, 8'h22, KEY_ENTER, KEY_ENTER, KEY_ENTER, KEY_ENTER, KEY_ENTER));
    send_report(key_report(2, KEY_NONE, KEY_ENTER));
    // Unknown codes, top bits set
    send_report(key_report(3, 8'h04, 8'hFF, 8'h80));
    // Overfill the buffer, then flush with the largest burst of digits
    for (int f = 0; f < 6; f++) begin
      fill_code = (f % 2 == 0) ? KEY_DIGIT_1 : KEY_KP_1;
      send_report(key_report(6, fill_code, fill_code, fill_code, fill_code, fill_code,
                             fill_code));
    end
    send_report(key_report(6, KEY_ENTER, KEY_KP_0, 8'h5B, 8'h5C, 8'h5D, KEY_KP_ENTER));
    send_report(key_report(3, 8'h24, 8'h25, KEY_BACKSPACE));
    send_report(key_report(2, KEY_ENTER, 8'h25));

    // Random reports; ignored empty reports do not count
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      cnt = $urandom_range(0, 99);
      if (cnt < 5) begin
        rep = unplug_report();
      end else begin
        rep = key_report((cnt < 10) ? 0 : $urandom_range(1, 7));
        foreach (rep.keys[i]) rep.keys[i] = random_key(last_sent);
      end
      send_report(rep);
      if (rep.opcode == OP_DISCONNECT || rep.slots_used != 0) counted++;
    end
    in_valid <= 1'b0;

    // Drain, then allow the block time to show any stray digit
    while (sb.pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hkne_pkg.sv
hdl/hkne_lane.sv
hdl/hkne_seq.sv
hdl/hid_keypad_number_entry_unit.sv
hdl/hkne_checker.sv
tb/sv/tb_hid_keypad_number_entry_unit.sv
